@@ sv/slew_limited_moving_average_defines.svh @@
// assertion macros for the slew limited moving average block
`ifndef SLEW_LIMITED_MOVING_AVERAGE_DEFINES_SVH
`define SLEW_LIMITED_MOVING_AVERAGE_DEFINES_SVH

// same-cycle implication
`define SLMA_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define SLMA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ sv/slma_pkg.sv @@
// shared constants for the slew limited moving average block
`timescale 1ns / 1ps

package slma_pkg;

  localparam int MAX_WINDOW = 16;
  localparam int DATA_W     = 32;
  localparam int WS_W       = 5;
  localparam int LIM_W      = 16;
  localparam int SLOT_W     = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int DIV_CNT_W  = $clog2(DATA_W);
  localparam int PADDR_W    = 3;

  localparam logic [WS_W-1:0]  WS_RESET  = WS_W'(4);
  localparam logic [LIM_W-1:0] LIM_RESET = LIM_W'(65535);

  localparam logic [PADDR_W-1:0] ADDR_WINDOW_SIZE = PADDR_W'(0);
  localparam logic [PADDR_W-1:0] ADDR_STEP_LIMIT  = PADDR_W'(4);

endpackage

@@ sv/slew_limited_moving_average.sv @@
// slew limited moving average filter, top level
//
//  channel  dir  handshake           payload
//  in       in   in_valid/in_ready   in_sample (s32)
//  out      out  out_valid/out_ready out_filtered (s32)
//  cfg      in   apb psel/penable    window_size @0x0, step_limit @0x4
//
//  one word visits n window slots, n the clamped window size (1..16)
//  each window slot runs one pass of the shared 32-step serial divider
//  window store sits in one ram; per-slot valid flags give zero after reset
//  one result word waits in the output register while the next word is taken
//  a word finishes only once the output register is free
`timescale 1ns / 1ps

module slew_limited_moving_average
  import slma_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic signed [DATA_W-1:0] in_sample,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic signed [DATA_W-1:0] out_filtered,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [PADDR_W-1:0]       paddr,
  input  logic [31:0]              pwdata,
  output logic [31:0]              prdata,
  output logic                     pready
);

`include "slew_limited_moving_average_defines.svh"

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_DATA,
    S_DIV,
    S_ACC,
    S_OUT
  } state_t;

  // configuration registers
  logic [WS_W-1:0]  window_size_r;
  logic [LIM_W-1:0] step_limit_r;
  logic             cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_size_r <= WS_RESET;
      step_limit_r  <= LIM_RESET;
    end else if (cfg_wr) begin
      if (paddr[2] == ADDR_STEP_LIMIT[2]) begin
        step_limit_r <= pwdata[LIM_W-1:0];
      end else begin
        window_size_r <= pwdata[WS_W-1:0];
      end
    end
  end

  always_comb begin
    if (paddr[2] == ADDR_STEP_LIMIT[2]) begin
      prdata = {{(32-LIM_W){1'b0}}, step_limit_r};
    end else begin
      prdata = {{(32-WS_W){1'b0}}, window_size_r};
    end
  end

  // datapath and control registers
  state_t                state_r, state_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic [MAX_WINDOW-1:0] valid_r, valid_nxt;
  logic [DATA_W-1:0]     sample_r, sample_nxt;
  logic [WS_W-1:0]       n_r, n_nxt;
  logic [LIM_W-1:0]      lim_r, lim_nxt;
  logic [SLOT_W-1:0]     slot_r, slot_nxt;
  logic [SLOT_W-1:0]     rd_addr_r, rd_addr_nxt;
  logic [DATA_W-1:0]     acc_r, acc_nxt;
  logic [DATA_W-1:0]     dvd_r, dvd_nxt;
  logic [WS_W-1:0]       rem_r, rem_nxt;
  logic                  neg_r, neg_nxt;
  logic [DIV_CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [DATA_W-1:0]     res_r, res_nxt;
  logic [DATA_W-1:0]     out_data_r, out_data_nxt;

  // ram ports
  logic              ram_we;
  logic [SLOT_W-1:0] ram_waddr;
  logic [DATA_W-1:0] ram_wdata;
  logic              ram_re;
  logic [SLOT_W-1:0] ram_raddr;
  logic [DATA_W-1:0] ram_rdata;

  slma_ram #(
    .WIDTH (DATA_W),
    .DEPTH (MAX_WINDOW),
    .AW    (SLOT_W)
  ) u_window_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign in_ready     = (state_r == S_IDLE);
  assign out_valid    = out_valid_r;
  assign out_filtered = out_data_r;

  always_comb begin
    logic [WS_W-1:0]          n_eff;
    logic [DATA_W-1:0]        rd_word;
    logic signed [DATA_W:0]   diff;
    logic signed [DATA_W:0]   lim_ext;
    logic [DATA_W-1:0]        lim_word;
    logic [DATA_W-1:0]        op_word;
    logic [WS_W:0]            rem_sh;
    logic                     ge;
    logic [WS_W:0]            rem_sub;
    logic [DATA_W-1:0]        quo;
    logic [DATA_W-1:0]        sum;

    state_nxt     = state_r;
    out_valid_nxt = out_valid_r;
    valid_nxt     = valid_r;
    sample_nxt    = sample_r;
    n_nxt         = n_r;
    lim_nxt       = lim_r;
    slot_nxt      = slot_r;
    rd_addr_nxt   = rd_addr_r;
    acc_nxt       = acc_r;
    dvd_nxt       = dvd_r;
    rem_nxt       = rem_r;
    neg_nxt       = neg_r;
    cnt_nxt       = cnt_r;
    res_nxt       = res_r;
    out_data_nxt  = out_data_r;

    ram_we    = 1'b0;
    ram_waddr = slot_r;
    ram_wdata = '0;
    ram_re    = 1'b0;
    ram_raddr = '0;

    if (window_size_r == '0) begin
      n_eff = WS_W'(1);
    end else if (32'(window_size_r) > MAX_WINDOW) begin
      n_eff = WS_W'(MAX_WINDOW);
    end else begin
      n_eff = window_size_r;
    end

    // slew clamp against the previous output, at 33 bits
    rd_word  = valid_r[rd_addr_r] ? ram_rdata : '0;
    lim_word = {{(DATA_W-LIM_W){1'b0}}, lim_r};
    lim_ext  = $signed({1'b0, lim_word});
    diff     = $signed({sample_r[DATA_W-1], sample_r}) - $signed({rd_word[DATA_W-1], rd_word});
    if (slot_r != '0) begin
      op_word = rd_word;
    end else if (diff > lim_ext) begin
      op_word = rd_word + lim_word;
    end else if (diff < -lim_ext) begin
      op_word = rd_word - lim_word;
    end else begin
      op_word = sample_r;
    end

    // one restoring divider step
    rem_sh  = {rem_r, dvd_r[DATA_W-1]};
    ge      = (rem_sh >= {1'b0, n_r});
    rem_sub = rem_sh - {1'b0, n_r};

    quo = neg_r ? (~dvd_r + DATA_W'(1)) : dvd_r;
    sum = acc_r + quo;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          sample_nxt = in_sample;
          n_nxt      = n_eff;
          lim_nxt    = step_limit_r;
          slot_nxt   = SLOT_W'(n_eff - WS_W'(1));
          acc_nxt    = '0;
          state_nxt  = S_READ;
        end
      end
      S_READ: begin
        ram_re      = 1'b1;
        ram_raddr   = (slot_r == '0) ? '0 : slot_r - SLOT_W'(1);
        rd_addr_nxt = ram_raddr;
        state_nxt   = S_DATA;
      end
      S_DATA: begin
        if (slot_r != '0) begin
          ram_we            = 1'b1;
          ram_waddr         = slot_r;
          ram_wdata         = rd_word;
          valid_nxt[slot_r] = 1'b1;
        end
        neg_nxt   = op_word[DATA_W-1];
        dvd_nxt   = op_word[DATA_W-1] ? (~op_word + DATA_W'(1)) : op_word;
        rem_nxt   = '0;
        cnt_nxt   = '0;
        state_nxt = S_DIV;
      end
      S_DIV: begin
        rem_nxt = ge ? rem_sub[WS_W-1:0] : rem_sh[WS_W-1:0];
        dvd_nxt = {dvd_r[DATA_W-2:0], ge};
        cnt_nxt = cnt_r + DIV_CNT_W'(1);
        if (cnt_r == DIV_CNT_W'(DATA_W - 1)) begin
          state_nxt = S_ACC;
        end
      end
      S_ACC: begin
        if (slot_r != '0) begin
          acc_nxt   = sum;
          slot_nxt  = slot_r - SLOT_W'(1);
          state_nxt = S_READ;
        end else begin
          ram_we       = 1'b1;
          ram_waddr    = '0;
          ram_wdata    = sum;
          valid_nxt[0] = 1'b1;
          res_nxt      = sum;
          state_nxt    = S_OUT;
        end
      end
      S_OUT: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = res_r;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      valid_r     <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      valid_r     <= valid_nxt;
    end
    sample_r   <= sample_nxt;
    n_r        <= n_nxt;
    lim_r      <= lim_nxt;
    slot_r     <= slot_nxt;
    rd_addr_r  <= rd_addr_nxt;
    acc_r      <= acc_nxt;
    dvd_r      <= dvd_nxt;
    rem_r      <= rem_nxt;
    neg_r      <= neg_nxt;
    cnt_r      <= cnt_nxt;
    res_r      <= res_nxt;
    out_data_r <= out_data_nxt;
  end

  // checks
  `SLMA_ASSERT_NOW(a_slot_in_window, state_r != S_IDLE && state_r != S_OUT, 32'(slot_r) < 32'(n_r), "slot index outside active window")
  `SLMA_ASSERT_NOW(a_rem_below_div, state_r == S_DIV, rem_r < n_r, "divider remainder not below divisor")
  `SLMA_ASSERT_NOW(a_shift_no_slot0, ram_we && state_r == S_DATA, ram_waddr != '0, "window shift wrote slot zero")
  `SLMA_ASSERT_NOW(a_n_range, state_r != S_IDLE, n_r != '0 && 32'(n_r) <= MAX_WINDOW, "window size out of range")
  `SLMA_ASSERT_NEXT(a_slot0_valid, state_r == S_ACC && slot_r == '0, valid_r[0] && state_r == S_OUT, "final write missing")

endmodule

@@ sv/slma_ram.sv @@
// generic single write port ram with registered read
`timescale 1ns / 1ps

module slma_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
